/* sv/hcc_pkg.sv */
`default_nettype none
package hcc_pkg;

  localparam int DEPTH     = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int IDX_W     = CNT_W + 1;
  localparam int DATA_W    = 32;
  localparam int VERDICT_W = 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [VERDICT_W-1:0]     verdict_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam verdict_t VERDICT_MAX_TO_MIN = 2'd0;
  localparam verdict_t VERDICT_MIN_TO_MAX = 2'd1;
  localparam verdict_t VERDICT_NEITHER    = 2'd2;

endpackage
`default_nettype wire

/* sv/hcc_if.sv */
`default_nettype none
interface hcc_in_if;
  import hcc_pkg::*;

  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface hcc_out_if;
  import hcc_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;
  data_t    element;
  logic     final_res;

  modport source (output valid, output verdict, output element, output final_res, input ready);
  modport sink   (input valid, input verdict, input element, input final_res, output ready);
endinterface
`default_nettype wire

/* sv/heap_check_and_convert.sv */
// Heap check and convert.
// in_ch carries one signed 32-bit value per beat; the beat with last set closes
// the set. Up to DEPTH values are kept; further values are dropped, though a
// dropped beat with last set still closes the set. While loading, one beat is
// taken per cycle.
// After the closing beat the block stops taking input and works through the
// stored values with one memory read port and one signed comparator under a
// sequencer: a max-heap check, then a min-heap check if needed, then a
// bottom-up heapify into the opposite order. Each check reads a parent, then
// its left child and, if present, its right child. Heapify visits nodes n/2
// down to 0, sinking each value level by level until it settles.
// out_ch then gives n beats in index order, with the verdict on each beat and
// final_res set on the last one, or a single beat with verdict 2 and element 0
// if the set is neither heap. Each result sits in an output register until
// taken; a stalled receiver simply holds the sequencer in its wait state.
// Reset (rst_n low, synchronous) empties the set and returns to loading; the
// memory contents are not cleared.
`default_nettype none
module heap_check_and_convert (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hcc_in_if.sink     in_ch,
  hcc_out_if.source  out_ch
);
  import hcc_pkg::*;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_CK_ROOT  = 4'd1;
  localparam logic [3:0] S_CK_PAR   = 4'd2;
  localparam logic [3:0] S_CK_CHILD = 4'd3;
  localparam logic [3:0] S_BD_NODE  = 4'd4;
  localparam logic [3:0] S_BD_PAR   = 4'd5;
  localparam logic [3:0] S_BD_CHILD = 4'd6;
  localparam logic [3:0] S_BD_SW1   = 4'd7;
  localparam logic [3:0] S_BD_SW2   = 4'd8;
  localparam logic [3:0] S_BD_NEXT  = 4'd9;
  localparam logic [3:0] S_OUT_RD   = 4'd10;
  localparam logic [3:0] S_OUT_LD   = 4'd11;
  localparam logic [3:0] S_OUT_WAIT = 4'd12;

  localparam cnt_t DEPTH_C = cnt_t'(DEPTH);

  // Element store: one write and one registered read per cycle.
  data_t mem [DEPTH];
  data_t rdata_r;
  addr_t raddr;
  addr_t waddr;
  data_t wdata;
  logic  we;

  logic [3:0] state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       n_r, n_nxt;
  cnt_t       i_r, i_nxt;
  cnt_t       k_r, k_nxt;
  idx_t       c_r, c_nxt;
  addr_t      node_r, node_nxt;
  addr_t      pick_r, pick_nxt;
  data_t      ref_r, ref_nxt;
  data_t      nodeval_r, nodeval_nxt;
  logic       mode_max_r, mode_max_nxt;
  verdict_t   verdict_r, verdict_nxt;

  logic       out_valid_r, out_valid_nxt;
  verdict_t   out_verdict_r, out_verdict_nxt;
  data_t      out_element_r, out_element_nxt;
  logic       out_final_r, out_final_nxt;

  // Shared comparator: in max direction, true when the held value is below the
  // value just read; in min direction, when the read value is below it.
  logic  to_max;
  logic  cmp_hit;
  data_t cmp_a, cmp_b;
  logic  in_checking;

  idx_t  c_root;
  idx_t  c_node;
  idx_t  c_pick;
  idx_t  c_inc;
  idx_t  n_ext;
  cnt_t  cnt_inc;

  assign in_checking = (state_r == S_CK_CHILD);
  assign to_max      = in_checking ? mode_max_r : (verdict_r == VERDICT_MIN_TO_MAX);
  assign cmp_a       = to_max ? ref_r : rdata_r;
  assign cmp_b       = to_max ? rdata_r : ref_r;
  assign cmp_hit     = (cmp_a < cmp_b);

  assign n_ext   = idx_t'(n_r);
  assign c_root  = {i_r, 1'b1};
  assign c_node  = idx_t'({node_r, 1'b1});
  assign c_pick  = idx_t'({pick_r, 1'b1});
  assign c_inc   = c_r + idx_t'(1);
  assign cnt_inc = count_r + cnt_t'(count_r < DEPTH_C);

  assign in_ch.ready      = (state_r == S_LOAD);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.verdict   = out_verdict_r;
  assign out_ch.element   = out_element_r;
  assign out_ch.final_res = out_final_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    n_nxt           = n_r;
    i_nxt           = i_r;
    k_nxt           = k_r;
    c_nxt           = c_r;
    node_nxt        = node_r;
    pick_nxt        = pick_r;
    ref_nxt         = ref_r;
    nodeval_nxt     = nodeval_r;
    mode_max_nxt    = mode_max_r;
    verdict_nxt     = verdict_r;
    out_valid_nxt   = out_valid_r;
    out_verdict_nxt = out_verdict_r;
    out_element_nxt = out_element_r;
    out_final_nxt   = out_final_r;
    raddr           = '0;
    waddr           = count_r[ADDR_W-1:0];
    wdata           = in_ch.value;
    we              = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_ch.valid) begin
          we        = (count_r < DEPTH_C);
          count_nxt = cnt_inc;
          if (in_ch.last) begin
            n_nxt        = cnt_inc;
            count_nxt    = '0;
            i_nxt        = '0;
            mode_max_nxt = 1'b1;
            state_nxt    = S_CK_ROOT;
          end
        end
      end

      S_CK_ROOT: begin
        if (c_root < n_ext) begin
          raddr     = i_r[ADDR_W-1:0];
          c_nxt     = c_root;
          state_nxt = S_CK_PAR;
        end else begin
          verdict_nxt = mode_max_r ? VERDICT_MAX_TO_MIN : VERDICT_MIN_TO_MAX;
          i_nxt       = n_r >> 1;
          state_nxt   = S_BD_NODE;
        end
      end

      S_CK_PAR: begin
        ref_nxt   = rdata_r;
        raddr     = c_r[ADDR_W-1:0];
        state_nxt = S_CK_CHILD;
      end

      S_CK_CHILD: begin
        if (cmp_hit) begin
          if (mode_max_r) begin
            mode_max_nxt = 1'b0;
            i_nxt        = '0;
            state_nxt    = S_CK_ROOT;
          end else begin
            out_valid_nxt   = 1'b1;
            out_verdict_nxt = VERDICT_NEITHER;
            out_element_nxt = '0;
            out_final_nxt   = 1'b1;
            state_nxt       = S_OUT_WAIT;
          end
        end else if (c_r[0] && (c_inc < n_ext)) begin
          c_nxt = c_inc;
          raddr = c_inc[ADDR_W-1:0];
        end else begin
          i_nxt     = i_r + cnt_t'(1);
          state_nxt = S_CK_ROOT;
        end
      end

      S_BD_NODE: begin
        node_nxt  = i_r[ADDR_W-1:0];
        raddr     = i_r[ADDR_W-1:0];
        state_nxt = S_BD_PAR;
      end

      S_BD_PAR: begin
        ref_nxt     = rdata_r;
        nodeval_nxt = rdata_r;
        pick_nxt    = node_r;
        c_nxt       = c_node;
        if (c_node < n_ext) begin
          raddr     = c_node[ADDR_W-1:0];
          state_nxt = S_BD_CHILD;
        end else begin
          state_nxt = S_BD_NEXT;
        end
      end

      S_BD_CHILD: begin
        if (cmp_hit) begin
          pick_nxt = c_r[ADDR_W-1:0];
          ref_nxt  = rdata_r;
        end
        if (c_r[0] && (c_inc < n_ext)) begin
          c_nxt = c_inc;
          raddr = c_inc[ADDR_W-1:0];
        end else begin
          state_nxt = S_BD_SW1;
        end
      end

      S_BD_SW1: begin
        if (pick_r == node_r) begin
          state_nxt = S_BD_NEXT;
        end else begin
          we        = 1'b1;
          waddr     = node_r;
          wdata     = ref_r;
          state_nxt = S_BD_SW2;
        end
      end

      S_BD_SW2: begin
        // The sifted value moves down into the slot of the chosen child.
        we       = 1'b1;
        waddr    = pick_r;
        wdata    = nodeval_r;
        node_nxt = pick_r;
        ref_nxt  = nodeval_r;
        c_nxt    = c_pick;
        if (c_pick < n_ext) begin
          raddr     = c_pick[ADDR_W-1:0];
          state_nxt = S_BD_CHILD;
        end else begin
          state_nxt = S_BD_NEXT;
        end
      end

      S_BD_NEXT: begin
        if (i_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          i_nxt     = i_r - cnt_t'(1);
          state_nxt = S_BD_NODE;
        end
      end

      S_OUT_RD: begin
        raddr     = k_r[ADDR_W-1:0];
        state_nxt = S_OUT_LD;
      end

      S_OUT_LD: begin
        out_valid_nxt   = 1'b1;
        out_verdict_nxt = verdict_r;
        out_element_nxt = rdata_r;
        out_final_nxt   = ((k_r + cnt_t'(1)) == n_r);
        state_nxt       = S_OUT_WAIT;
      end

      S_OUT_WAIT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_final_r) begin
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + cnt_t'(1);
            raddr     = k_nxt[ADDR_W-1:0];
            state_nxt = S_OUT_LD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    i_r           <= i_nxt;
    k_r           <= k_nxt;
    c_r           <= c_nxt;
    node_r        <= node_nxt;
    pick_r        <= pick_nxt;
    ref_r         <= ref_nxt;
    nodeval_r     <= nodeval_nxt;
    mode_max_r    <= mode_max_nxt;
    verdict_r     <= verdict_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_element_r <= out_element_nxt;
    out_final_r   <= out_final_nxt;
  end

endmodule
`default_nettype wire
